// ----- rtl/swt_pkg.sv -----
// Shared types, character codes and helpers of the shell word tokenizer.
// Used by rtl/shell_word_tokenizer.sv and rtl/swt_checker.sv; depends on nothing.

package swt_pkg;

    // Token kinds as they appear on the result stream.
    typedef enum logic [2:0] {
        KIND_CHAR      = 3'd0,
        KIND_WORD_END  = 3'd1,
        KIND_OP        = 3'd2,
        KIND_LINE_END  = 3'd3,
        KIND_INPUT_END = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic        doubled;
        logic        quote_error;
    } t_result;

    localparam int unsigned MaxResults = 3;

    // Bit positions of the result fields inside the output tdata.
    localparam int unsigned OutKindLsb  = 0;
    localparam int unsigned OutValueLsb = 3;
    localparam int unsigned OutDblBit   = 11;
    localparam int unsigned OutQerrBit  = 12;

    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;

    // True for any character that forms an operator outside quotes.
    function automatic logic is_operator(input logic [7:0] c);
        logic hit;
        case (c) inside
            CH_PIPE, CH_GT, CH_LT, CH_SEMI, CH_AMP, CH_LPAREN, CH_RPAREN: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // True for an operator that may take a second, equal character.
    function automatic logic can_double(input logic [7:0] c);
        logic hit;
        case (c) inside
            CH_GT, CH_PIPE, CH_AMP: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic t_result mk_result(input t_kind kind, input logic [7:0] value,
                                          input logic doubled, input logic quote_error);
        t_result r;
        r.kind        = kind;
        r.value       = value;
        r.doubled     = doubled;
        r.quote_error = quote_error;
        return r;
    endfunction

endpackage

// ----- rtl/shell_word_tokenizer.sv -----
// Streaming shell lexer top level: character beats in, token beats out.
// Depends on rtl/swt_pkg.sv.
//
//  Channel   Dir  tdata (lowest bit up)                                   tlast
//  s_axis    in   char_code[7:0]                                          end_of_input
//  m_axis    out  kind[2:0] value[10:3] doubled[11] quote_error[12] 0[15:13]
//                                                                         last of an item
//
// Each character beat first lands in an input register. In the cycle it moves on,
// the lexer decides its zero to two token beats from the quote, word and
// pending-operator flags, and those beats are written to a three-entry result
// register that drains one beat per cycle while m_axis_tready is high. A new
// item's beats are loaded in the cycle the last beat of the one before is taken,
// so the drain sets the pace; a character's first token leaves from the result
// register. While it still holds beats, one more character is held in the input
// register, so the input side takes that one beat while a result waits and then
// stalls until the result register can be loaded. Reset (i_rst_n low at a clock
// edge) empties both registers and clears all lexer flags.

module shell_word_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code[7:0]
    input  logic        s_axis_tlast,   // end_of_input

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // kind[2:0], value[10:3], doubled[11],
                                        // quote_error[12], zero[15:13]
    output logic        m_axis_tlast    // last token of the input item
);

    // Input register.
    logic        r_in_vld;
    logic [7:0]  r_in_char;
    logic        r_in_end;

    // Lexer flags.
    logic        r_sq, n_sq;
    logic        r_dq, n_dq;
    logic        r_word, n_word;
    logic        r_op_pend, n_op_pend;
    logic [7:0]  r_op_char, n_op_char;

    // Result register: entry 0 is the one on the output port.
    swt_pkg::t_result r_res [swt_pkg::MaxResults];
    swt_pkg::t_result n_res [swt_pkg::MaxResults];
    logic [1:0]       r_cnt, n_cnt;

    logic             take;
    logic             load;

    assign take          = m_axis_tvalid && m_axis_tready;
    // The lexer result may be written when the result register is empty or is
    // handing out its final beat in this cycle.
    assign load          = r_in_vld && ((r_cnt == 2'd0) || (take && r_cnt == 2'd1));
    assign s_axis_tready = !r_in_vld || load;

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tlast  = (r_cnt == 2'd1);
    assign m_axis_tdata  = {3'b000, r_res[0].quote_error, r_res[0].doubled,
                            r_res[0].value, r_res[0].kind};

    // Lexer: results and next flags for the character in the input register.
    always_comb begin
        logic [1:0] idx;
        logic       qerr;
        idx       = 2'd0;
        qerr      = r_sq || r_dq;
        n_sq      = r_sq;
        n_dq      = r_dq;
        n_word    = r_word;
        n_op_pend = r_op_pend;
        n_op_char = r_op_char;
        for (int i = 0; i < swt_pkg::MaxResults; i++) begin
            n_res[i] = '0;
        end

        if (r_op_pend && !r_in_end && r_in_char == r_op_char) begin
            // Second equal character: the doubled operator is all this beat makes.
            n_res[idx] = swt_pkg::mk_result(swt_pkg::KIND_OP, r_op_char, 1'b1, 1'b0);
            idx        = idx + 2'd1;
            n_op_pend  = 1'b0;
        end else begin
            if (r_op_pend) begin
                n_res[idx] = swt_pkg::mk_result(swt_pkg::KIND_OP, r_op_char, 1'b0, 1'b0);
                idx        = idx + 2'd1;
                n_op_pend  = 1'b0;
            end

            if (r_in_end) begin
                if (r_word) begin
                    n_res[idx] = swt_pkg::mk_result(swt_pkg::KIND_WORD_END, 8'h00,
                                                    1'b0, 1'b0);
                    idx        = idx + 2'd1;
                end
                n_res[idx] = swt_pkg::mk_result(swt_pkg::KIND_INPUT_END, 8'h00, 1'b0, qerr);
                idx        = idx + 2'd1;
                // The stream is over: all flags return to their reset values.
                n_sq      = 1'b0;
                n_dq      = 1'b0;
                n_word    = 1'b0;
                n_op_pend = 1'b0;
                n_op_char = 8'h00;
            end else if (r_in_char == swt_pkg::CH_SQUOTE) begin
                n_sq = !r_sq;
            end else if (r_in_char == swt_pkg::CH_DQUOTE) begin
                n_dq = !r_dq;
            end else if (qerr) begin
                // Inside either quote everything else is literal.
                n_word     = 1'b1;
                n_res[idx] = swt_pkg::mk_result(swt_pkg::KIND_CHAR, r_in_char, 1'b0, 1'b0);
                idx        = idx + 2'd1;
            end else if (r_in_char == swt_pkg::CH_SPACE
                         || r_in_char == swt_pkg::CH_NEWLINE) begin
                if (r_word) begin
                    n_res[idx] = swt_pkg::mk_result(swt_pkg::KIND_WORD_END, 8'h00,
                                                    1'b0, 1'b0);
                    idx        = idx + 2'd1;
                    n_word     = 1'b0;
                end
                if (r_in_char == swt_pkg::CH_NEWLINE) begin
                    n_res[idx] = swt_pkg::mk_result(swt_pkg::KIND_LINE_END, 8'h00,
                                                    1'b0, 1'b0);
                    idx        = idx + 2'd1;
                end
            end else if (swt_pkg::is_operator(r_in_char)) begin
                if (r_word) begin
                    n_res[idx] = swt_pkg::mk_result(swt_pkg::KIND_WORD_END, 8'h00,
                                                    1'b0, 1'b0);
                    idx        = idx + 2'd1;
                    n_word     = 1'b0;
                end
                if (swt_pkg::can_double(r_in_char)) begin
                    n_op_pend = 1'b1;
                    n_op_char = r_in_char;
                end else begin
                    n_res[idx] = swt_pkg::mk_result(swt_pkg::KIND_OP, r_in_char,
                                                    1'b0, 1'b0);
                    idx        = idx + 2'd1;
                end
            end else begin
                n_word     = 1'b1;
                n_res[idx] = swt_pkg::mk_result(swt_pkg::KIND_CHAR, r_in_char, 1'b0, 1'b0);
                idx        = idx + 2'd1;
            end
        end
        n_cnt = idx;
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (load) begin
            r_in_vld <= 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_end  <= s_axis_tlast;
        end
    end

    // Lexer flags advance only when an item's results are committed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq      <= 1'b0;
            r_dq      <= 1'b0;
            r_word    <= 1'b0;
            r_op_pend <= 1'b0;
            r_op_char <= 8'h00;
        end else if (load) begin
            r_sq      <= n_sq;
            r_dq      <= n_dq;
            r_word    <= n_word;
            r_op_pend <= n_op_pend;
            r_op_char <= n_op_char;
        end
    end

    // Result register: load a new set, or shift one entry down per taken beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (load) begin
            r_cnt <= n_cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
        if (load) begin
            r_res <= n_res;
        end else if (take) begin
            for (int i = 0; i < swt_pkg::MaxResults - 1; i++) begin
                r_res[i] <= r_res[i + 1];
            end
        end
    end

endmodule

// ----- rtl/swt_checker.sv -----
// Port-level checks of the shell word tokenizer, attached by a bind statement.
// Depends on rtl/swt_pkg.sv and rtl/shell_word_tokenizer.sv.

module swt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic [2:0] kind;
    assign kind = m_axis_tdata[swt_pkg::OutKindLsb +: 3];

    // A quote error is only ever reported on the input-end token.
    a_qerr_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[swt_pkg::OutQerrBit]
        |-> kind == swt_pkg::KIND_INPUT_END)
        else $error("quote error on a token other than input end");

    // The input-end token is always the final beat of its item.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && kind == swt_pkg::KIND_INPUT_END |-> m_axis_tlast)
        else $error("input end token not marked last");

    // A doubled operator consumes its whole item and is an operator.
    a_double_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[swt_pkg::OutDblBit]
        |-> kind == swt_pkg::KIND_OP && m_axis_tlast)
        else $error("doubled flag on a bad token");

    // Marker tokens carry no character.
    a_marker_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (kind == swt_pkg::KIND_WORD_END || kind == swt_pkg::KIND_LINE_END
                          || kind == swt_pkg::KIND_INPUT_END)
        |-> m_axis_tdata[swt_pkg::OutValueLsb +: 8] == 8'h00)
        else $error("marker token with nonzero value");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

endmodule

bind shell_word_tokenizer swt_checker u_swt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
